[design/papu_pkg.sv]
// Shared types, constants and a helper function of the pixel pair arithmetic unit.
package papu_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int DIV_STEPS  = 32;
  localparam logic [15:0] PIX_MASK = 16'((32'd1 << PIXEL_BITS) - 32'd1);

  localparam logic CFG_DEPTH  = 1'b0;
  localparam logic CFG_WEIGHT = 1'b1;

  typedef enum logic [3:0] {
    MODE_AND   = 4'd0,
    MODE_OR    = 4'd1,
    MODE_XOR   = 4'd2,
    MODE_NOT   = 4'd3,
    MODE_BLEND = 4'd4,
    MODE_ADD   = 4'd5,
    MODE_SUB   = 4'd6,
    MODE_MUL   = 4'd7,
    MODE_DIV   = 4'd8,
    MODE_MAX   = 4'd9,
    MODE_MIN   = 4'd10
  } mode_t;

  typedef struct packed {
    logic        vld;
    mode_t       mode;
    logic        neg;
    logic [31:0] simple;
    logic [16:0] divisor;
    logic [16:0] rem;
    logic [31:0] num;
  } papu_word_t;

  function automatic logic [15:0] clamp16(input logic [15:0] v, input logic [15:0] lim);
    clamp16 = (v > lim) ? lim : v;
  endfunction

endpackage

[design/papu_front.sv]
// Front end: operand capture, simple results, product and divider set-up.
module papu_front import papu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [3:0]  in_mode,
  input  logic [15:0] in_pixel_a,
  input  logic [15:0] in_pixel_b,
  input  logic [15:0] depth,
  input  logic [8:0]  weight,
  output papu_word_t  word_o
);

  logic        vld_r;
  logic [3:0]  mode_r;
  logic [15:0] a_r, b_r, d_r;
  logic [8:0]  w_r;
  papu_word_t  word_r, word_nxt;

  logic [15:0] mx, mn, sum16, nt;
  logic [16:0] sum, dp1;
  logic [24:0] bl_sum;
  logic [16:0] mx_op;
  logic [32:0] prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= in_mode;
    a_r    <= in_pixel_a & PIX_MASK;
    b_r    <= in_pixel_b & PIX_MASK;
    d_r    <= (depth == 16'd0) ? 16'd1 : depth;
    w_r    <= (weight > 9'd256) ? 9'd256 : weight;
  end

  always_comb begin
    mx     = (a_r > b_r) ? a_r : b_r;
    mn     = (a_r < b_r) ? a_r : b_r;
    sum    = {1'b0, a_r} + {1'b0, b_r};
    sum16  = (sum > {1'b0, d_r}) ? d_r : sum[15:0];
    nt     = (a_r > d_r) ? 16'd0 : d_r - a_r;
    bl_sum = 25'(w_r) * 25'(a_r) + 25'(9'd256 - w_r) * 25'(b_r);
    dp1    = {1'b0, d_r} + 17'd1;
    mx_op  = (mode_r == MODE_DIV) ? dp1 : {1'b0, b_r};
    prod   = 33'(mx_op) * 33'(a_r);

    word_nxt         = '0;
    word_nxt.vld     = vld_r;
    word_nxt.mode    = mode_t'(mode_r);
    word_nxt.neg     = a_r < b_r;
    word_nxt.divisor = 17'd1;
    unique case (mode_r)
      MODE_AND:   word_nxt.simple = {16'd0, clamp16(a_r & b_r, d_r)};
      MODE_OR:    word_nxt.simple = {16'd0, clamp16(a_r | b_r, d_r)};
      MODE_XOR:   word_nxt.simple = {16'd0, clamp16(a_r ^ b_r, d_r)};
      MODE_NOT:   word_nxt.simple = {16'd0, nt};
      MODE_BLEND: word_nxt.simple = {15'd0, bl_sum[24:8]};
      MODE_ADD:   word_nxt.simple = {16'd0, sum16};
      MODE_SUB: begin
        word_nxt.divisor = dp1;
        word_nxt.num     = {16'd0, (a_r >= b_r) ? a_r - b_r : b_r - a_r};
      end
      MODE_MUL: begin
        word_nxt.divisor = {1'b0, d_r};
        word_nxt.num     = prod[31:0];
      end
      MODE_DIV: begin
        word_nxt.divisor = {1'b0, b_r} + 17'd1;
        word_nxt.num     = prod[31:0];
      end
      MODE_MAX:   word_nxt.simple = {16'd0, clamp16(mx, d_r)};
      MODE_MIN:   word_nxt.simple = {16'd0, clamp16(mn, d_r)};
      default:    word_nxt.simple = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.vld <= 1'b0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign word_o = word_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    word_r.vld |-> word_r.divisor != 17'd0) else $error("zero divisor entered chain");

endmodule

[design/papu_div_cell.sv]
// One restoring division step: moves one quotient bit per cycle.
module papu_div_cell import papu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  papu_word_t word_i,
  output papu_word_t word_o
);

  papu_word_t  word_r, word_nxt;
  logic [17:0] trial;
  logic        q;

  always_comb begin
    trial    = {word_i.rem, word_i.num[31]};
    q        = trial >= {1'b0, word_i.divisor};
    word_nxt = word_i;
    word_nxt.rem = q ? 17'(trial - {1'b0, word_i.divisor}) : trial[16:0];
    word_nxt.num = {word_i.num[30:0], q};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.vld <= 1'b0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign word_o = word_r;

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    word_r.vld |-> word_r.rem < word_r.divisor) else $error("remainder not below divisor");
  a_vld_moves: assert property (@(posedge clk) disable iff (!rst_n)
    word_i.vld |=> word_r.vld) else $error("word lost in chain");

endmodule

[design/papu_back.sv]
// Back end: picks the final pixel from the quotient, remainder or simple result.
module papu_back import papu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  papu_word_t  word_i,
  output logic        out_valid,
  output logic [31:0] out_pixel_out
);

  logic        valid_r;
  logic [31:0] pix_r, pix_nxt;
  logic        sub_r;
  logic [16:0] lim_r;

  always_comb begin
    unique case (word_i.mode)
      MODE_SUB: begin
        if (word_i.neg && word_i.rem != 17'd0) begin
          pix_nxt = {15'd0, word_i.divisor - word_i.rem};
        end else begin
          pix_nxt = {15'd0, word_i.rem};
        end
      end
      MODE_MUL, MODE_DIV: pix_nxt = word_i.num;
      default:            pix_nxt = word_i.simple;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= word_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
    sub_r <= word_i.mode == MODE_SUB;
    lim_r <= word_i.divisor;
  end

  assign out_valid     = valid_r;
  assign out_pixel_out = pix_r;

  a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && sub_r |-> out_pixel_out < {15'd0, lim_r}) else $error("sub result out of range");

endmodule

[design/pixel_pair_arithmetic_unit_top.sv]
// Top level of the pixel pair arithmetic unit: registers, pipeline and division chain.
//
// Channel  Ports                                   Handshake
// input    in_mode, in_pixel_a, in_pixel_b         start high, busy low
// result   out_pixel_out                           out_valid strobe, one cycle
// config   cfg_index, cfg_wdata                    cfg_we
//
// One word is taken every cycle; busy is always low.
// The pipeline has two front stages, 32 division cells and one output stage.
// The 32-cell restoring divider chain sets the latency, not the rate.
// Reset is synchronous and clears the valid bits; registers return to 255 and 128.
// The receiver cannot stall; each result shows for exactly one cycle.
module pixel_pair_arithmetic_unit_top import papu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_mode,
  input  logic [15:0] in_pixel_a,
  input  logic [15:0] in_pixel_b,
  output logic        out_valid,
  output logic [31:0] out_pixel_out,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] depth_r;
  logic [8:0]  weight_r;
  papu_word_t  chain [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= 16'd255;
      weight_r <= 9'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEPTH:  depth_r  <= cfg_wdata;
        CFG_WEIGHT: weight_r <= cfg_wdata[8:0];
        default:    depth_r  <= depth_r;
      endcase
    end
  end

  assign busy = 1'b0;

  papu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (start && !busy),
    .in_mode    (in_mode),
    .in_pixel_a (in_pixel_a),
    .in_pixel_b (in_pixel_b),
    .depth      (depth_r),
    .weight     (weight_r),
    .word_o     (chain[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    papu_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .word_i (chain[i]),
      .word_o (chain[i+1])
    );
  end

  papu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .word_i        (chain[DIV_STEPS]),
    .out_valid     (out_valid),
    .out_pixel_out (out_pixel_out)
  );

endmodule
